// File: rtl/core/dve_pkg.sv
package dve_pkg;

    localparam int VALUE_BITS     = 64;
    localparam int MAX_CODE_BYTES = 10;
    localparam int GROUP_BITS     = 7;
    localparam int CNT_W          = $clog2(MAX_CODE_BYTES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_TIME    = 2'd0;
    localparam logic [1:0] KIND_COUNT   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [7:0] CONT_FLAG = 8'h80;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      byte_cnt_t;

endpackage

// File: rtl/core/delta_varint_encoder_top.sv
// The first byte of a value reaches m_tdata through the queue, the serializer's value
// register and its output register. A value of N code bytes (1 to 10) goes out one
// byte per cycle while m_tready allows; the serializer sets the rate.
// Requests enter at one per cycle while the 2-entry queue has room.
// Reset: asynchronous, active low; clears history to zero, sets both first-value flags,
// empties the queue and drops any byte in flight.
module delta_varint_encoder_top
    import dve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_value[63:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // code_byte[7:0]
    output logic        m_tlast
);

    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    value_t q_wdata;
    value_t q_rdata;

    dve_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_value (s_tdata[VALUE_BITS-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    dve_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    dve_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: rtl/core/dve_front.sv
module dve_front
    import dve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_kind,
    input  value_t     in_value,
    input  logic       q_full,
    output logic       q_push,
    output value_t     q_data
);

    value_t prev_time_reg,  prev_time_next;
    value_t prev_count_reg, prev_count_next;
    logic   time_first_reg,  time_first_next;
    logic   count_first_reg, count_first_next;
    logic   take;

    assign in_ready = !q_full;
    assign take     = in_valid && !q_full;

    always_comb
    begin
        prev_time_next   = prev_time_reg;
        prev_count_next  = prev_count_reg;
        time_first_next  = time_first_reg;
        count_first_next = count_first_reg;
        q_push           = 1'b0;
        q_data           = in_value;
        if (take)
        begin
            priority if (in_kind == KIND_TIME)
            begin
                q_push          = 1'b1;
                q_data          = time_first_reg ? in_value : (in_value - prev_time_reg);
                prev_time_next  = in_value;
                time_first_next = 1'b0;
            end
            else if (in_kind == KIND_COUNT)
            begin
                q_push           = 1'b1;
                q_data           = count_first_reg ? in_value : (in_value - prev_count_reg);
                prev_count_next  = in_value;
                count_first_next = 1'b0;
            end
            else if (in_kind == KIND_RESTART)
            begin
                prev_time_next   = '0;
                prev_count_next  = '0;
                time_first_next  = 1'b1;
                count_first_next = 1'b1;
            end
            else
            begin
                // unused kind: drop
                q_push = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg   <= '0;
            prev_count_reg  <= '0;
            time_first_reg  <= 1'b1;
            count_first_reg <= 1'b1;
        end
        else
        begin
            prev_time_reg   <= prev_time_next;
            prev_count_reg  <= prev_count_next;
            time_first_reg  <= time_first_next;
            count_first_reg <= count_first_next;
        end
    end

endmodule

// File: rtl/core/dve_queue.sv
module dve_queue
    import dve_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  value_t push_data,
    input  logic   pop,
    output value_t pop_data,
    output logic   full,
    output logic   empty
);

    value_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/dve_back.sv
module dve_back
    import dve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  value_t     q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam byte_cnt_t LAST_IDX = CNT_W'(MAX_CODE_BYTES - 1);

    value_t     val_reg,   val_next;
    byte_cnt_t  cnt_reg,   cnt_next;
    logic       busy_reg,  busy_next;
    logic       ovalid_reg, ovalid_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;
    logic       grp_last;
    logic [7:0] grp_byte;
    logic       out_free;
    logic       emit;

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        grp_last = (val_reg < value_t'(CONT_FLAG)) || (cnt_reg == LAST_IDX);
        grp_byte = grp_last ? val_reg[7:0] : (CONT_FLAG | {1'b0, val_reg[GROUP_BITS-1:0]});
        out_free = !ovalid_reg || out_ready;
        emit     = busy_reg && out_free;
        q_pop    = !busy_reg && !q_empty;
    end

    always_comb
    begin
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (out_free)
        begin
            ovalid_next = 1'b0;
        end
        if (q_pop)
        begin
            val_next  = q_data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (emit)
        begin
            ovalid_next = 1'b1;
            obyte_next  = grp_byte;
            olast_next  = grp_last;
            // advance to the next 7-bit group
            val_next    = val_reg >> GROUP_BITS;
            cnt_next    = cnt_reg + 1'b1;
            busy_next   = !grp_last;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= LAST_IDX))
        else $error("byte index past the longest code");

    a_cont_set: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !olast_reg) |-> obyte_reg[7])
        else $error("inner byte lacks continuation flag");

    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && olast_reg) |-> !obyte_reg[7])
        else $error("final byte carries continuation flag");
`endif

endmodule

// File: dv/dve_stream_checker.sv
module dve_stream_checker
    import dve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_value[63:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // code_byte[7:0]
    input  logic        m_tlast,
    output int          fail_count,
    output int          open_bytes,
    output int          bytes_seen,
    output int          runs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } code_byte_t;

    code_byte_t code_q[$];
    value_t     last_stamp;
    value_t     last_tally;
    logic       stamp_fresh;
    logic       tally_fresh;

    initial
    begin
        fail_count = 0;
        open_bytes = 0;
        bytes_seen = 0;
        runs_seen  = 0;
    end

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Split a value into 7-bit groups, low group first; the tenth byte takes what is left.
    function automatic void push_varint(value_t v);
        value_t     rest;
        int         n;
        code_byte_t item;
        rest = v;
        n    = 0;
        while (rest >= value_t'(CONT_FLAG) && n < MAX_CODE_BYTES - 1)
        begin
            item.code = CONT_FLAG | {1'b0, rest[6:0]};
            item.last = 1'b0;
            code_q.insert(code_q.size(), item);
            rest = rest >> GROUP_BITS;
            n++;
        end
        item.code = rest[7:0];
        item.last = 1'b1;
        code_q.insert(code_q.size(), item);
    endfunction

    function automatic void encode_sample(logic [1:0] kind, value_t sample);
        case (kind)
            KIND_TIME:
            begin
                push_varint(stamp_fresh ? sample : sample - last_stamp);
                last_stamp  = sample;
                stamp_fresh = 1'b0;
            end
            KIND_COUNT:
            begin
                push_varint(tally_fresh ? sample : sample - last_tally);
                last_tally  = sample;
                tally_fresh = 1'b0;
            end
            KIND_RESTART:
            begin
                last_stamp  = '0;
                last_tally  = '0;
                stamp_fresh = 1'b1;
                tally_fresh = 1'b1;
            end
            default:
            begin
                // unused kind: drop it
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        code_byte_t want;
        if (!rst_n)
        begin
            code_q.delete();
            last_stamp  = '0;
            last_tally  = '0;
            stamp_fresh = 1'b1;
            tally_fresh = 1'b1;
        end
        else
        begin
            if (s_tvalid && s_tready)
                encode_sample(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                bytes_seen++;
                if (m_tlast)
                    runs_seen++;
                if (code_q.size() == 0)
                    report_mismatch($sformatf("unexpected code byte %02h last %b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = code_q.pop_front();
                    if (m_tdata !== want.code)
                        report_mismatch($sformatf("code byte got %02h want %02h",
                                                  m_tdata, want.code));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("run end got %b want %b on byte %02h",
                                                  m_tlast, want.last, want.code));
                end
            end
        end
        open_bytes = code_q.size();
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dve_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS     = 420;
    localparam int SINK_HOLD_CYCLES = 200;
    localparam int STUCK_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int fail_count;
    int open_bytes;
    int bytes_seen;
    int runs_seen;

    bit          no_idle      = 1'b0;
    int          hold_ticket  = 0;
    int          stuck_cycles = 0;
    int          n_stamp      = 0;
    int          n_tally      = 0;
    int          n_restart    = 0;
    int          n_unused     = 0;
    logic [63:0] stamp_base   = '0;
    logic [63:0] tally_base   = '0;

    always #5 clk = ~clk;

    delta_varint_encoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    dve_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .open_bytes (open_bytes),
        .bytes_seen (bytes_seen),
        .runs_seen  (runs_seen)
    );

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Timeout: no request or code byte moved for %0d cycles", STUCK_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Sink: random back-pressure per byte, plus one long hold per ticket.
    initial
    begin : sink
        int gap;
        int holds_served;
        holds_served = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_served != hold_ticket)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
                holds_served++;
            end
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    function automatic logic [63:0] random_bits();
        int          w;
        logic [63:0] full;
        w    = $urandom_range(0, 64);
        full = {$urandom(), $urandom()};
        return (w == 64) ? full : full & ((64'd1 << w) - 64'd1);
    endfunction

    task automatic send_req(logic [1:0] kind, logic [63:0] sample);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= sample;
        do @(posedge clk); while (!s_tready);
        case (kind)
            KIND_TIME:    n_stamp++;
            KIND_COUNT:   n_tally++;
            KIND_RESTART: n_restart++;
            default:      n_unused++;
        endcase
    endtask

    // Mostly small or large steps from the last value of the kind, some jumps back.
    task automatic send_random_req(bit values_only);
        int          pick;
        int          mode;
        logic [1:0]  kind;
        logic [63:0] base;
        logic [63:0] sample;
        pick = values_only ? $urandom_range(10, 99) : $urandom_range(0, 99);
        if (pick < 3)
            kind = KIND_RESTART;
        else if (pick < 5)
            kind = KIND_UNUSED;
        else
            kind = pick[0] ? KIND_COUNT : KIND_TIME;
        base = (kind == KIND_COUNT) ? tally_base : stamp_base;
        mode = $urandom_range(0, 3);
        case (mode)
            0:       sample = random_bits();
            1, 2:    sample = base + random_bits();
            default: sample = base - random_bits();
        endcase
        if (kind == KIND_TIME)
            stamp_base = sample;
        if (kind == KIND_COUNT)
            tally_base = sample;
        send_req(kind, sample);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_TIME;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first values go out whole, then deltas of 1 to 3, 9 and 10 bytes, and wrap
        send_req(KIND_TIME,    64'd0);
        send_req(KIND_COUNT,   64'hFFFF_FFFF_FFFF_FFFF);
        send_req(KIND_TIME,    64'h7F);
        send_req(KIND_TIME,    64'hFF);
        send_req(KIND_COUNT,   64'd0);
        send_req(KIND_COUNT,   64'd5);
        send_req(KIND_COUNT,   64'd2);
        send_req(KIND_UNUSED,  64'h1234_5678_9ABC_DEF0);
        send_req(KIND_TIME,    64'hFF);
        send_req(KIND_RESTART, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(KIND_TIME,    64'h8000_0000_0000_0000);
        send_req(KIND_COUNT,   64'h3FFF);
        send_req(KIND_TIME,    64'd0);
        send_req(KIND_COUNT,   64'h7FFF);
        send_req(KIND_UNUSED,  64'hFFFF_FFFF_FFFF_FFFF);
        send_req(KIND_RESTART, 64'd0);
        send_req(KIND_COUNT,   64'hFFFF_FFFF_FFFF_FFFF);
        send_req(KIND_TIME,    64'h5555_5555_5555_5555);
        send_req(KIND_TIME,    64'hAAAA_AAAA_AAAA_AAAA);
        send_req(KIND_RESTART, 64'hAAAA_AAAA_AAAA_AAAA);
        send_req(KIND_RESTART, 64'h5555_5555_5555_5555);
        send_req(KIND_TIME,    64'h7FFF_FFFF_FFFF_FFFF);
        send_req(KIND_COUNT,   64'h80);
        send_req(KIND_COUNT,   64'h7F);
        go_quiet();
        wait (open_bytes == 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60 || i == 300)
            begin
                // stall the sink while requests keep coming, so the input backs up
                hold_ticket++;
                no_idle = 1'b1;
                repeat (14) send_random_req(1'b1);
            end
            if (i == 120 || i == 360)
            begin
                go_quiet();
                wait (open_bytes == 0);
            end
            no_idle = (i >= 150 && i < 230);
            send_random_req(1'b0);
        end
        go_quiet();
        wait (open_bytes == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d timestamp, %0d counter, %0d restart, %0d unused kind",
                 n_stamp + n_tally + n_restart + n_unused, n_stamp, n_tally, n_restart,
                 n_unused);
        $display("Checked %0d code bytes in %0d runs, with long sink stalls and full-rate bursts",
                 bytes_seen, runs_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
